/* rtl/core/stepper_half_step_positioner_top_macros.svh */
// ----------------------------------------------------------------------------
// Stepper half-step positioner assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef STEPPER_HALF_STEP_POSITIONER_TOP_MACROS_SVH
`define STEPPER_HALF_STEP_POSITIONER_TOP_MACROS_SVH

// Same-cycle implication.
`define SHSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SHSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/shsp_pkg.sv */
// ----------------------------------------------------------------------------
// Stepper half-step positioner package
// Widths, codes, register layout, result layout and the half-step coil table.
// ----------------------------------------------------------------------------
`default_nettype none

package shsp_pkg;

  localparam int unsigned FuncW    = 2;
  localparam int unsigned AngleW   = 9;
  localparam int unsigned CoilW    = 4;
  localparam int unsigned DelayW   = 16;
  localparam int unsigned SpqW     = 13;
  localparam int unsigned MagW     = 8;
  localparam int unsigned ProdW    = 21;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned DiffW    = 11;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  localparam logic [FuncW-1:0] FUNC_TICK = 2'd0;
  localparam logic [FuncW-1:0] FUNC_MOVE = 2'd1;
  localparam logic [FuncW-1:0] FUNC_HOME = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_DELAY_MOVE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DELAY_HOME = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SPQ        = 2'd2;

  localparam logic [DelayW-1:0] DELAY_MOVE_RST = 16'd2;
  localparam logic [DelayW-1:0] DELAY_HOME_RST = 16'd3;
  localparam logic [SpqW-1:0]   SPQ_RST        = 13'd1024;

  localparam logic [AngleW-1:0]       FULL_TURN  = 9'd360;
  localparam logic signed [DiffW-1:0] FULL_TURN_S = 11'sd360;
  localparam logic signed [DiffW-1:0] HALF_TURN_S = 11'sd180;
  localparam logic [ProdW-1:0]        QUARTER    = 21'd90;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_MOVE = 2'd1,
    MODE_HOME = 2'd2
  } mode_t;

  typedef struct packed {
    logic [DelayW-1:0] delay_move;
    logic [DelayW-1:0] delay_home;
    logic [SpqW-1:0]   spq;
  } cfg_t;

  typedef struct packed {
    logic              command_ignored;
    logic              run_done;
    logic [AngleW-1:0] position_angle;
    logic              busy_res;
    logic [CoilW-1:0]  coil_pattern;
  } res_t;

  function automatic logic [CoilW-1:0] coil_of(input logic [PhaseW-1:0] phase);
    logic [CoilW-1:0] pat;
    case (phase)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      3'd7:    pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/stepper_half_step_positioner_top.sv */
// ----------------------------------------------------------------------------
// Stepper half-step positioner
// Half-step coil sequencer with absolute angle moves and limit-switch homing.
//
//   Channel  Direction  Handshake             Payload
//   in_      slave      in_tvalid/in_tready   tdata: target_angle, limit_open;
//                                             tuser: func
//   out_     master     out_tvalid/out_tready tdata: coil, busy, angle, done,
//                                             ignored
//   cfg_     slave      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One item is taken per cycle unless out_tready stalls the output.
// The rate is set by the single registered pass from the input register through
// the run state update into the output register.
// Reset is synchronous and active low; it restores the default delays and
// steps per quarter turn and leaves the run idle with all coils off.
// A stalled out_tready holds the result and, once the input register is full,
// holds in_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_half_step_positioner_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  // [8:0] target_angle, [9] limit_open, [15:10] zero
  input  wire logic [shsp_pkg::InDataW-1:0]   in_tdata,
  // [1:0] func
  input  wire logic [shsp_pkg::FuncW-1:0]     in_tuser,
  output      logic                           out_tvalid,
  input  wire logic                           out_tready,
  // [3:0] coil_pattern, [4] busy_res, [13:5] position_angle, [14] run_done,
  // [15] command_ignored
  output      logic [shsp_pkg::OutDataW-1:0]  out_tdata,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [shsp_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [shsp_pkg::CfgDataW-1:0]  cfg_data
);

  `include "stepper_half_step_positioner_top_macros.svh"

  logic                          in_valid_r, in_valid_nxt;
  logic [shsp_pkg::AngleW-1:0]   tgt_r;
  logic                          limit_r;
  logic [shsp_pkg::FuncW-1:0]    func_r;
  logic                          out_valid_r, out_valid_nxt;
  shsp_pkg::res_t                res_r;
  shsp_pkg::res_t                res_nxt;
  shsp_pkg::cfg_t                cfg;
  logic                          in_take;
  logic                          cfg_take;
  logic                          fire;

  assign cfg_ready = rst_n;
  assign cfg_take  = cfg_valid && cfg_ready;

  shsp_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_take),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  shsp_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .func         (func_r),
    .target_angle (tgt_r),
    .limit_open   (limit_r),
    .cfg          (cfg),
    .res          (res_nxt)
  );

  always_comb begin
    fire          = in_valid_r && (!out_valid_r || out_tready);
    in_tready     = rst_n && (!in_valid_r || fire);
    in_take       = in_tvalid && in_tready;
    in_valid_nxt  = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_r);
    out_valid_nxt = fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      tgt_r   <= in_tdata[shsp_pkg::AngleW-1:0];
      limit_r <= in_tdata[shsp_pkg::AngleW];
      func_r  <= in_tuser;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

  `SHSP_ASSERT_IMP(a_done_not_ignored, out_valid_r && res_r.run_done,
                   !res_r.command_ignored, "run_done and command_ignored together")
  `SHSP_ASSERT_IMP(a_done_is_idle, out_valid_r && res_r.run_done,
                   !res_r.busy_res, "completed run still reports busy")
  `SHSP_ASSERT_IMP(a_ignored_is_busy, out_valid_r && res_r.command_ignored,
                   res_r.busy_res, "command dropped while not busy")
  `SHSP_ASSERT_NXT(a_item_kept, in_valid_r && out_valid_r && !out_tready,
                   in_valid_r, "waiting item lost under output stall")

endmodule

`default_nettype wire

/* rtl/core/shsp_cfg.sv */
// ----------------------------------------------------------------------------
// Stepper half-step positioner configuration registers
// Holds the move delay, homing delay and steps per quarter turn.
// ----------------------------------------------------------------------------
`default_nettype none

module shsp_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [shsp_pkg::CfgIdxW-1:0]   wr_index,
  input  wire logic [shsp_pkg::CfgDataW-1:0]  wr_data,
  output shsp_pkg::cfg_t                      cfg
);

  shsp_pkg::cfg_t cfg_r;
  shsp_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        shsp_pkg::REG_DELAY_MOVE: cfg_nxt.delay_move = wr_data;
        shsp_pkg::REG_DELAY_HOME: cfg_nxt.delay_home = wr_data;
        shsp_pkg::REG_SPQ:        cfg_nxt.spq        = wr_data[shsp_pkg::SpqW-1:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_move <= shsp_pkg::DELAY_MOVE_RST;
      cfg_r.delay_home <= shsp_pkg::DELAY_HOME_RST;
      cfg_r.spq        <= shsp_pkg::SPQ_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/core/shsp_core.sv */
// ----------------------------------------------------------------------------
// Stepper half-step positioner core
// Run state and the single-pass update for one item, with its result.
// ----------------------------------------------------------------------------
`default_nettype none

module shsp_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          fire,
  input  wire logic [shsp_pkg::FuncW-1:0]    func,
  input  wire logic [shsp_pkg::AngleW-1:0]   target_angle,
  input  wire logic                          limit_open,
  input  wire shsp_pkg::cfg_t                cfg,
  output shsp_pkg::res_t                     res
);

  // The remaining move length is kept as the undivided product; one half step
  // consumes ninety of it, and the move ends when less than ninety is left.
  logic [shsp_pkg::PhaseW-1:0] phase_r, phase_nxt;
  logic [shsp_pkg::CoilW-1:0]  coil_r, coil_nxt;
  logic [shsp_pkg::ProdW-1:0]  acc_r, acc_nxt;
  logic                        dir_r, dir_nxt;
  logic [shsp_pkg::DelayW-1:0] wait_r, wait_nxt;
  shsp_pkg::mode_t             mode_r, mode_nxt;
  logic [shsp_pkg::AngleW-1:0] angle_r, angle_nxt;

  logic [shsp_pkg::AngleW-1:0]        tgt_fix;
  logic signed [shsp_pkg::DiffW-1:0]  diff_raw;
  logic signed [shsp_pkg::DiffW-1:0]  diff;
  logic signed [shsp_pkg::DiffW-1:0]  diff_abs;
  logic [shsp_pkg::MagW-1:0]          mag;
  logic [shsp_pkg::ProdW-1:0]         prod;
  logic [shsp_pkg::DelayW-1:0]        wait_dec;
  logic [shsp_pkg::PhaseW-1:0]        phase_step;
  logic [shsp_pkg::ProdW-1:0]         acc_dec;
  logic [shsp_pkg::DelayW-1:0]        delay_move_eff;
  logic [shsp_pkg::DelayW-1:0]        delay_home_eff;
  logic                               done;
  logic                               ignored;

  always_comb begin
    tgt_fix  = (target_angle >= shsp_pkg::FULL_TURN) ? target_angle - shsp_pkg::FULL_TURN
                                                       : target_angle;
    diff_raw = $signed({2'b00, tgt_fix}) - $signed({2'b00, angle_r});
    if (diff_raw > shsp_pkg::HALF_TURN_S) begin
      diff = diff_raw - shsp_pkg::FULL_TURN_S;
    end else if (diff_raw < -shsp_pkg::HALF_TURN_S) begin
      diff = diff_raw + shsp_pkg::FULL_TURN_S;
    end else begin
      diff = diff_raw;
    end
    diff_abs = diff[shsp_pkg::DiffW-1] ? -diff : diff;
    mag      = diff_abs[shsp_pkg::MagW-1:0];
    prod     = shsp_pkg::ProdW'(cfg.spq) * shsp_pkg::ProdW'(mag);

    wait_dec   = (wait_r != '0) ? wait_r - 1'b1 : wait_r;
    phase_step = dir_r ? phase_r - 1'b1 : phase_r + 1'b1;
    acc_dec    = acc_r - shsp_pkg::QUARTER;
    delay_move_eff = (cfg.delay_move == '0) ? shsp_pkg::DelayW'(1) : cfg.delay_move;
    delay_home_eff = (cfg.delay_home == '0) ? shsp_pkg::DelayW'(1) : cfg.delay_home;
  end

  always_comb begin
    phase_nxt = phase_r;
    coil_nxt  = coil_r;
    acc_nxt   = acc_r;
    dir_nxt   = dir_r;
    wait_nxt  = wait_r;
    mode_nxt  = mode_r;
    angle_nxt = angle_r;
    done      = 1'b0;
    ignored   = 1'b0;
    case (func)
      shsp_pkg::FUNC_MOVE: begin
        if (mode_r != shsp_pkg::MODE_IDLE) begin
          ignored = 1'b1;
        end else begin
          dir_nxt   = diff[shsp_pkg::DiffW-1];
          acc_nxt   = prod;
          angle_nxt = tgt_fix;
          if (prod < shsp_pkg::QUARTER) begin
            done = 1'b1;
          end else begin
            mode_nxt = shsp_pkg::MODE_MOVE;
            wait_nxt = shsp_pkg::DelayW'(1);
          end
        end
      end
      shsp_pkg::FUNC_HOME: begin
        if (mode_r != shsp_pkg::MODE_IDLE) begin
          ignored = 1'b1;
        end else begin
          mode_nxt = shsp_pkg::MODE_HOME;
          dir_nxt  = 1'b1;
          wait_nxt = shsp_pkg::DelayW'(1);
        end
      end
      shsp_pkg::FUNC_TICK: begin
        case (mode_r)
          shsp_pkg::MODE_MOVE: begin
            wait_nxt = wait_dec;
            if (wait_dec == '0) begin
              phase_nxt = phase_step;
              coil_nxt  = shsp_pkg::coil_of(phase_step);
              acc_nxt   = acc_dec;
              if (acc_dec < shsp_pkg::QUARTER) begin
                mode_nxt = shsp_pkg::MODE_IDLE;
                done     = 1'b1;
              end else begin
                wait_nxt = delay_move_eff;
              end
            end
          end
          shsp_pkg::MODE_HOME: begin
            if (!limit_open) begin
              phase_nxt = '0;
              coil_nxt  = shsp_pkg::coil_of('0);
              angle_nxt = '0;
              wait_nxt  = '0;
              mode_nxt  = shsp_pkg::MODE_IDLE;
              done      = 1'b1;
            end else begin
              wait_nxt = wait_dec;
              if (wait_dec == '0) begin
                phase_nxt = phase_step;
                coil_nxt  = shsp_pkg::coil_of(phase_step);
                wait_nxt  = delay_home_eff;
              end
            end
          end
          default: begin
            mode_nxt = mode_r;
          end
        endcase
      end
      default: begin
        ignored = 1'b0;
      end
    endcase

    res.coil_pattern    = coil_nxt;
    res.busy_res        = (mode_nxt != shsp_pkg::MODE_IDLE);
    res.position_angle  = angle_nxt;
    res.run_done        = done;
    res.command_ignored = ignored;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      coil_r  <= '0;
      acc_r   <= '0;
      dir_r   <= 1'b0;
      wait_r  <= '0;
      mode_r  <= shsp_pkg::MODE_IDLE;
      angle_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      coil_r  <= coil_nxt;
      acc_r   <= acc_nxt;
      dir_r   <= dir_nxt;
      wait_r  <= wait_nxt;
      mode_r  <= mode_nxt;
      angle_r <= angle_nxt;
    end
  end

endmodule

`default_nettype wire
